// ===== rtl/core/rfms_pkg.sv =====
// shared constants and types for the row farthest-from-mean select block
package rfms_pkg;

  // default row store depth and element width
  localparam int MAX_ROW_LEN = 128;
  localparam int VALUE_WIDTH = 16;

  // control states: load row, scan store, drain scan pipeline
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN
  } state_t;

endpackage

// ===== rtl/core/rfms_ram.sv =====
// generic single write port, single read port ram with registered read
module rfms_ram #(
  parameter int WIDTH = rfms_pkg::VALUE_WIDTH,
  parameter int DEPTH = rfms_pkg::MAX_ROW_LEN,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/row_farthest_from_mean_select_core.sv =====
// top level: stores a row, then scans it for the element farthest from the row mean
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+--------------------------------
//  input    | in_value, in_last_in_row                | taken when start && !busy
//  result   | out_farthest_value                      | out_valid strobe, one cycle
//
// loading accepts one element per cycle while busy is low; each element goes into the
// row ram at the running count while the sum and count update. an element marked last
// starts a scan: one ram read is issued per stored element, then each read passes the
// ram read, multiply and subtract/abs stages before the compare lands in the result
// register. busy is high from the cycle after the last element until the strobe,
// which arrives in the first ready cycle; the result cannot be held off by the
// receiver.
// synchronous reset clears control state, the ram keeps data.
module row_farthest_from_mean_select_core #(
  parameter int MAX_ROW_LEN = rfms_pkg::MAX_ROW_LEN,
  parameter int VALUE_WIDTH = rfms_pkg::VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          in_last_in_row,
  output logic                          busy,
  output logic                          out_valid,
  output logic signed [VALUE_WIDTH-1:0] out_farthest_value
);

  localparam int CNT_W  = $clog2(MAX_ROW_LEN + 1);
  localparam int ADDR_W = (MAX_ROW_LEN > 1) ? $clog2(MAX_ROW_LEN) : 1;
  localparam int SUM_W  = VALUE_WIDTH + CNT_W;
  localparam int PROD_W = SUM_W + 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ROW_LEN);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  rfms_pkg::state_t state_r, state_nxt;

  logic [CNT_W-1:0]        count_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0]        rd_idx_r;

  logic                    accept;
  logic                    ram_we;
  logic [VALUE_WIDTH-1:0]  ram_rdata;
  logic                    issue;
  logic                    issue_last;

  // scan pipeline stages
  logic                     s1_v_r, s1_last_r;
  logic                     s2_v_r, s2_last_r;
  logic signed [PROD_W-1:0] s2_prod_r;
  logic signed [VALUE_WIDTH-1:0] s2_val_r;
  logic                     s3_v_r, s3_last_r;
  logic [PROD_W-1:0]        s3_dist_r;
  logic signed [VALUE_WIDTH-1:0] s3_val_r;

  logic                     have_best_r;
  logic [PROD_W-1:0]        best_dist_r;
  logic signed [VALUE_WIDTH-1:0] best_val_r;
  logic                     take_new;
  logic signed [VALUE_WIDTH-1:0] cand_val;

  logic signed [PROD_W-1:0] prod_a, prod_b, diff;
  logic [PROD_W-1:0]        abs_dist;

  logic                          out_valid_r;
  logic signed [VALUE_WIDTH-1:0] out_val_r;

  // request handshake; elements past the store depth are dropped
  assign busy   = (state_r != rfms_pkg::ST_LOAD);
  assign accept = start && !busy;
  assign ram_we = accept && (count_r < MAX_CNT);

  // row store
  rfms_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (MAX_ROW_LEN)
  ) u_row_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_value),
    .raddr (rd_idx_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // next state and scan issue
  always_comb begin
    state_nxt  = state_r;
    issue      = 1'b0;
    issue_last = (rd_idx_r == (count_r - ONE_CNT));
    case (state_r)
      rfms_pkg::ST_LOAD: begin
        if (accept && in_last_in_row) begin
          state_nxt = rfms_pkg::ST_SCAN;
        end
      end
      rfms_pkg::ST_SCAN: begin
        issue = 1'b1;
        if (issue_last) begin
          state_nxt = rfms_pkg::ST_DRAIN;
        end
      end
      rfms_pkg::ST_DRAIN: begin
        if (s3_v_r && s3_last_r) begin
          state_nxt = rfms_pkg::ST_LOAD;
        end
      end
      default: begin
        state_nxt = rfms_pkg::ST_LOAD;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rfms_pkg::ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // running sum and count; cleared when the result goes out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (s3_v_r && s3_last_r) begin
      count_r <= '0;
      sum_r   <= '0;
    end else if (ram_we) begin
      count_r <= count_r + ONE_CNT;
      sum_r   <= sum_r + SUM_W'(in_value);
    end
  end

  // read address walks the stored row
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r <= '0;
    end else if (issue) begin
      rd_idx_r <= issue_last ? '0 : rd_idx_r + ONE_CNT;
    end
  end

  // distance datapath: n*x, then |n*x - sum|
  assign prod_a   = PROD_W'($signed({1'b0, count_r}));
  assign prod_b   = PROD_W'($signed(ram_rdata));
  assign diff     = s2_prod_r - PROD_W'(sum_r);
  assign abs_dist = diff[PROD_W-1] ? PROD_W'(-diff) : PROD_W'(diff);

  // pipeline valid and last tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      s1_last_r <= 1'b0;
      s2_v_r    <= 1'b0;
      s2_last_r <= 1'b0;
      s3_v_r    <= 1'b0;
      s3_last_r <= 1'b0;
    end else begin
      s1_v_r    <= issue;
      s1_last_r <= issue && issue_last;
      s2_v_r    <= s1_v_r;
      s2_last_r <= s1_last_r;
      s3_v_r    <= s2_v_r;
      s3_last_r <= s2_last_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    s2_prod_r <= prod_a * prod_b;
    s2_val_r  <= $signed(ram_rdata);
    s3_dist_r <= abs_dist;
    s3_val_r  <= s2_val_r;
  end

  // strict greater-than keeps the earliest element on a tie
  assign take_new = !have_best_r || (s3_dist_r > best_dist_r);
  assign cand_val = take_new ? s3_val_r : best_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_best_r <= 1'b0;
    end else if (s3_v_r) begin
      have_best_r <= !s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && take_new) begin
      best_dist_r <= s3_dist_r;
      best_val_r  <= s3_val_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= s3_v_r && s3_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && s3_last_r) begin
      out_val_r <= cand_val;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_farthest_value = out_val_r;

  // the store is only written while loading
  a_we_only_loading: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == rfms_pkg::ST_LOAD))
    else $error("row store written outside of loading");

  // scan never reads past the stored row
  a_scan_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfms_pkg::ST_SCAN) |-> (rd_idx_r < count_r))
    else $error("scan address beyond stored row");

  // a scan always covers at least one element
  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfms_pkg::ST_SCAN) |-> (count_r != '0))
    else $error("scan started on an empty row");

  // result strobe leaves the block ready with a cleared row
  a_out_clears_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && (count_r == '0) && (sum_r == '0)))
    else $error("row state not cleared at result");

  // count never exceeds the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= MAX_CNT)
    else $error("row count beyond store depth");

endmodule
